// ===== rtl/pmha_pkg.sv =====
// ----------------------------------------------------------------------------
// pmha_pkg
// Types and constants shared by the page map heap allocator modules.
// ----------------------------------------------------------------------------
package pmha_pkg;

  localparam int unsigned NUM_PAGES   = 8192;
  localparam int unsigned PAGE_W      = 13;
  localparam int unsigned CNT_W       = 14;
  localparam int unsigned PAGE_SHIFT  = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] HEAP_OFFSET = 32'h0004_0000;
  localparam logic [31:0] RAM_BYTES   = 32'h0024_0000;
  localparam logic [31:0] MAX_BYTES   = 32'h0020_0000;
  localparam logic [15:0] CONT_MARK   = 16'hffff;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_FREE    = 2'd1;
  localparam logic [1:0] ACT_LARGEST = 2'd2;
  localparam logic [1:0] ACT_TOTAL   = 2'd3;

  localparam logic [1:0] MODE_LOW  = 2'd0;
  localparam logic [1:0] MODE_HIGH = 2'd1;
  localparam logic [1:0] MODE_FIX  = 2'd2;
  localparam logic [1:0] MODE_BAD  = 2'd3;

  localparam logic [2:0] OP_FAIL    = 3'd0;
  localparam logic [2:0] OP_LOW     = 3'd1;
  localparam logic [2:0] OP_HIGH    = 3'd2;
  localparam logic [2:0] OP_FIX     = 3'd3;
  localparam logic [2:0] OP_FREE    = 3'd4;
  localparam logic [2:0] OP_LARGEST = 3'd5;
  localparam logic [2:0] OP_TOTAL   = 3'd6;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  alloc_mode;
    logic [31:0] byte_count;
    logic [31:0] req_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        fail;
  } out_item_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  count;
  } cmd_t;

endpackage

// ===== rtl/page_map_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// page_map_heap_allocator
// Page map heap allocator with lowest, highest and fixed fit and free runs.
// ----------------------------------------------------------------------------
// After reset the page map is cleared; requests are queued meanwhile. Lowest
// and highest fit allocations and queries scan the 8192-entry page map one
// entry per cycle through its read port; a fixed allocation reads only the
// pages of its block. An allocation or free then writes its block one page
// per cycle. Results appear on out_item for one cycle, marked by out_valid;
// the receiver cannot stall them.
module page_map_heap_allocator import pmha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] ram_base_r;
  logic        accept;
  logic        cmd_valid, q_avail, q_pop;
  cmd_t        cmd, q_head;
  logic [1:0]  q_fill;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_base_r <= '0;
    end else if (cfg_we) begin
      ram_base_r <= cfg_wdata;
    end
  end

  assign busy   = ({1'b0, q_fill} + {2'b00, cmd_valid}) >= 3'(QUEUE_DEPTH);
  assign accept = start && !busy;

  pmha_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_item),
    .ram_base (ram_base_r),
    .cmd_valid(cmd_valid),
    .cmd      (cmd)
  );

  pmha_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_valid),
    .push_cmd (cmd),
    .pop      (q_pop),
    .not_empty(q_avail),
    .head     (q_head),
    .fill     (q_fill)
  );

  pmha_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ram_base (ram_base_r),
    .cmd_avail(q_avail),
    .cmd      (q_head),
    .pop      (q_pop),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.fail |-> out_item.value == 32'd0)
    else $error("failed result carries a nonzero value");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_fill <= 2'(QUEUE_DEPTH))
    else $error("command queue overflow");

endmodule

// ===== rtl/pmha_front.sv =====
// ----------------------------------------------------------------------------
// pmha_front
// Accepts requests, checks sizes and addresses and turns them into commands.
// ----------------------------------------------------------------------------
module pmha_front import pmha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  in_item_t    in_item,
  input  logic [31:0] ram_base,
  output logic        cmd_valid,
  output cmd_t        cmd
);

  cmd_t              cmd_r, cmd_nxt;
  logic              vld_r;
  logic [31:0]       abs_addr;
  logic [32:0]       lo, hi, diff;
  logic              addr_ok, size_ok;
  logic [PAGE_W-1:0] page;
  logic [CNT_W-1:0]  count;
  logic [PAGE_W+1:0] fix_end;

  always_comb begin
    abs_addr = (in_item.req_address < RAM_BYTES) ? in_item.req_address + ram_base
                                                 : in_item.req_address;
    lo       = {1'b0, ram_base} + {1'b0, HEAP_OFFSET};
    hi       = {1'b0, ram_base} + {1'b0, RAM_BYTES};
    diff     = {1'b0, abs_addr} - lo;
    addr_ok  = ({1'b0, abs_addr} >= lo) && ({1'b0, abs_addr} < hi) &&
               (abs_addr[PAGE_SHIFT-1:0] == '0);
    page     = diff[PAGE_SHIFT+PAGE_W-1:PAGE_SHIFT];
    size_ok  = (in_item.byte_count != '0) && (in_item.byte_count <= MAX_BYTES);
    count    = in_item.byte_count[PAGE_SHIFT+CNT_W-1:PAGE_SHIFT] +
               CNT_W'(|in_item.byte_count[PAGE_SHIFT-1:0]);
    fix_end  = {2'b00, page} + {1'b0, count};
    cmd_nxt.page  = page;
    cmd_nxt.count = count;
    cmd_nxt.op    = OP_FAIL;
    unique case (in_item.action)
      ACT_ALLOC: begin
        if (size_ok) begin
          priority case (in_item.alloc_mode)
            MODE_LOW:  cmd_nxt.op = OP_LOW;
            MODE_HIGH: cmd_nxt.op = OP_HIGH;
            MODE_FIX:  cmd_nxt.op = (addr_ok && fix_end <= (PAGE_W+2)'(NUM_PAGES))
                                    ? OP_FIX : OP_FAIL;
            default:   cmd_nxt.op = OP_FAIL;
          endcase
        end
      end
      ACT_FREE:    cmd_nxt.op = addr_ok ? OP_FREE : OP_FAIL;
      ACT_LARGEST: cmd_nxt.op = OP_LARGEST;
      ACT_TOTAL:   cmd_nxt.op = OP_TOTAL;
      default:     cmd_nxt.op = OP_FAIL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= accept;
    end
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = vld_r;
  assign cmd       = cmd_r;

endmodule

// ===== rtl/pmha_queue.sv =====
// ----------------------------------------------------------------------------
// pmha_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module pmha_queue import pmha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_t       push_cmd,
  input  logic       pop,
  output logic       not_empty,
  output cmd_t       head,
  output logic [1:0] fill
);

  cmd_t       slot_r [QUEUE_DEPTH];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

  assign not_empty = (cnt_r != 2'd0);
  assign head      = slot_r[rd_r];
  assign fill      = cnt_r;

endmodule

// ===== rtl/pmha_back.sv =====
// ----------------------------------------------------------------------------
// pmha_back
// Holds the page map and carries out scans, block writes and queries.
// ----------------------------------------------------------------------------
module pmha_back import pmha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] ram_base,
  input  logic        cmd_avail,
  input  cmd_t        cmd,
  output logic        pop,
  output logic        out_valid,
  output out_item_t   out_item
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_FILL = 3'd3;

  logic [15:0]       mem [NUM_PAGES];
  logic [15:0]       rdata_r;
  logic [2:0]        st_r;
  logic [2:0]        op_r;
  logic [PAGE_W-1:0] p_r, pend_idx_r, w_r, clr_r, base_page_r;
  logic [CNT_W-1:0]  left_r, count_r, run_r, best_r, total_r, fill_left_r;
  logic              pend_r;
  logic [15:0]       fill_val_r, cont_val_r;
  logic [31:0]       res_r;
  logic              ov_r;
  out_item_t         oi_r;

  logic              we, issue;
  logic [PAGE_W-1:0] wa;
  logic [15:0]       wd;
  logic [CNT_W-1:0]  run_nxt;
  logic              is_free;
  logic [PAGE_W-1:0] hit_start;
  logic [16:0]       room;
  logic [CNT_W-1:0]  free_cnt;

  always_comb begin
    we    = (st_r == ST_CLR) || (st_r == ST_FILL);
    wa    = (st_r == ST_CLR) ? clr_r : w_r;
    wd    = (st_r == ST_CLR) ? 16'h0000 : fill_val_r;
    issue = (st_r == ST_SCAN) && (left_r != '0);
    is_free   = (rdata_r == 16'h0000);
    run_nxt   = is_free ? run_r + 1'b1 : '0;
    hit_start = (op_r == OP_LOW) ? pend_idx_r - count_r[PAGE_W-1:0] + 1'b1
              : (op_r == OP_HIGH) ? pend_idx_r : base_page_r;
    room      = 17'(NUM_PAGES) - {4'd0, pend_idx_r};
    free_cnt  = ({1'b0, rdata_r} < room) ? rdata_r[CNT_W-1:0] : room[CNT_W-1:0];
    pop       = (st_r == ST_IDLE) && cmd_avail;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[p_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLR;
      clr_r  <= '0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      ov_r   <= 1'b0;
      pend_r <= issue;
      unique case (st_r)
        ST_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == PAGE_W'(NUM_PAGES - 1)) begin
            st_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_avail) begin
            op_r        <= cmd.op;
            count_r     <= cmd.count;
            base_page_r <= cmd.page;
            run_r       <= '0;
            best_r      <= '0;
            total_r     <= '0;
            priority case (cmd.op)
              OP_FAIL: begin
                ov_r          <= 1'b1;
                oi_r.value    <= '0;
                oi_r.fail     <= 1'b1;
              end
              OP_HIGH: begin
                p_r    <= PAGE_W'(NUM_PAGES - 1);
                left_r <= CNT_W'(NUM_PAGES);
                st_r   <= ST_SCAN;
              end
              OP_FIX: begin
                p_r    <= cmd.page;
                left_r <= cmd.count;
                st_r   <= ST_SCAN;
              end
              OP_FREE: begin
                p_r    <= cmd.page;
                left_r <= CNT_W'(1);
                st_r   <= ST_SCAN;
              end
              default: begin
                p_r    <= '0;
                left_r <= CNT_W'(NUM_PAGES);
                st_r   <= ST_SCAN;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (issue) begin
            p_r    <= (op_r == OP_HIGH) ? p_r - 1'b1 : p_r + 1'b1;
            left_r <= left_r - 1'b1;
          end
          if (pend_r) begin
            priority case (op_r)
              OP_FREE: begin
                pend_r <= 1'b0;
                if (is_free || rdata_r == CONT_MARK) begin
                  ov_r       <= 1'b1;
                  oi_r.value <= '0;
                  oi_r.fail  <= 1'b1;
                  st_r       <= ST_IDLE;
                end else begin
                  w_r         <= pend_idx_r;
                  fill_left_r <= free_cnt;
                  fill_val_r  <= 16'h0000;
                  cont_val_r  <= 16'h0000;
                  res_r       <= '0;
                  st_r        <= ST_FILL;
                end
              end
              OP_LARGEST, OP_TOTAL: begin
                run_r <= run_nxt;
                if (is_free) begin
                  total_r <= total_r + 1'b1;
                end
                if (run_nxt > best_r) begin
                  best_r <= run_nxt;
                end
              end
              default: begin
                run_r <= run_nxt;
                if (is_free && run_nxt == count_r) begin
                  pend_r      <= 1'b0;
                  w_r         <= hit_start;
                  fill_left_r <= count_r;
                  fill_val_r  <= 16'(count_r);
                  cont_val_r  <= CONT_MARK;
                  res_r       <= ram_base + HEAP_OFFSET +
                                 {{(32-PAGE_W-PAGE_SHIFT){1'b0}}, hit_start,
                                  {PAGE_SHIFT{1'b0}}};
                  st_r        <= ST_FILL;
                end
              end
            endcase
          end else if (left_r == '0) begin
            ov_r      <= 1'b1;
            oi_r.fail <= 1'b0;
            priority case (op_r)
              OP_LARGEST: oi_r.value <= 32'({best_r, {PAGE_SHIFT{1'b0}}});
              OP_TOTAL:   oi_r.value <= 32'({total_r, {PAGE_SHIFT{1'b0}}});
              default: begin
                oi_r.value <= '0;
                oi_r.fail  <= 1'b1;
              end
            endcase
            st_r <= ST_IDLE;
          end
        end
        ST_FILL: begin
          w_r         <= w_r + 1'b1;
          fill_left_r <= fill_left_r - 1'b1;
          fill_val_r  <= cont_val_r;
          if (fill_left_r == CNT_W'(1)) begin
            ov_r       <= 1'b1;
            oi_r.value <= res_r;
            oi_r.fail  <= 1'b0;
            st_r       <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_idx_r <= p_r;
    end
  end

  assign out_valid = ov_r;
  assign out_item  = oi_r;

endmodule
